[sv/ldm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldm_pkg: shared constants for the lagged-delta min-entropy monitor
// Field widths, configuration register codes and default parameter values.
// ----------------------------------------------------------------------------
package ldm_pkg;

  // default structural parameters
  localparam int DEF_LAG_DISTANCE = 12;
  localparam int DEF_SAMPLE_BITS  = 12;
  localparam int DEF_CHANNELS     = 2;

  // fixed field widths
  localparam int IN_TDATA_W  = 16;
  localparam int COUNT_W     = 16;
  localparam int RANGE_W     = 12;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - COUNT_W - RANGE_W - 1;

  // histogram batch tag; a full wrap of it forces a clearing pass
  localparam int EPOCH_W = 8;

  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int DEF_QE_W    = 2 * DEF_SAMPLE_BITS + 2;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_RANGE   = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT_LIMIT = CFG_ADDR_W'(1);

  localparam logic [RANGE_W-1:0] MIN_RANGE_RST   = RANGE_W'(200);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT_RST = COUNT_W'(256);

endpackage

[sv/ldm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldm_front: sample intake and lagged-delta classification
// Masks each sample, tracks batch min/max, reads and refreshes the per-channel
// lag ring and hands the centered delta plus batch info to the queue.
// ----------------------------------------------------------------------------
module ldm_front #(
  parameter int LAG_DISTANCE = ldm_pkg::DEF_LAG_DISTANCE,
  parameter int SAMPLE_BITS  = ldm_pkg::DEF_SAMPLE_BITS,
  parameter int CHANNELS     = ldm_pkg::DEF_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ldm_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] sample
  input  logic                              in_tuser,   // [0] channel
  input  logic                              in_tlast,
  input  logic                              hist_clearing,
  output logic                              q_push,
  input  logic                              q_ready,
  output logic [2*SAMPLE_BITS+1:0]          q_data
);
  import ldm_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int HEAD_W = (LAG_DISTANCE > 1) ? $clog2(LAG_DISTANCE) : 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(LAG_DISTANCE - 1);
  localparam logic [SB:0]       MIN_INIT  = (SB + 1)'(1) << SB;
  localparam logic [SB-1:0]     HALF      = SB'(1) << (SB - 1);

  logic [SB-1:0]     lag_mem [CHANNELS][LAG_DISTANCE];
  logic [HEAD_W-1:0] head_r  [CHANNELS];
  logic [CHANNELS-1:0] wrapped_r;

  logic [SB:0]   min_r;
  logic [SB-1:0] max_r;

  logic          f1_valid_r;
  logic [SB-1:0] f1_val_r;
  logic [SB-1:0] lag_rd_r;
  logic          f1_oldok_r;
  logic [SB-1:0] f1_range_r;
  logic          f1_chan_r;
  logic          f1_last_r;

  logic          accept;
  logic [CH_W-1:0]   ch_idx;
  logic [HEAD_W-1:0] cur_head;
  logic [SB-1:0] val;
  logic [SB:0]   mn_new;
  logic [SB-1:0] mx_new;
  logic [SB-1:0] range_new;
  logic [SB-1:0] old_val;
  logic [SB-1:0] delta;

  assign in_tready = (!f1_valid_r || q_ready) && !hist_clearing;
  assign accept    = in_tvalid && in_tready;
  assign ch_idx    = (CHANNELS > 1) ? CH_W'(in_tuser) : '0;
  assign cur_head  = head_r[ch_idx];
  assign val       = in_tdata[SB-1:0];

  assign mn_new    = ({1'b0, val} < min_r) ? {1'b0, val} : min_r;
  assign mx_new    = (val > max_r) ? val : max_r;
  assign range_new = mx_new - mn_new[SB-1:0];

  // lag ring: read-first, so the returned word is the one from a full lag ago
  always_ff @(posedge clk) begin
    if (accept) begin
      lag_rd_r                  <= lag_mem[ch_idx][cur_head];
      lag_mem[ch_idx][cur_head] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        head_r[i] <= '0;
      end
      wrapped_r <= '0;
    end else if (accept) begin
      if (cur_head == HEAD_LAST) begin
        head_r[ch_idx]    <= '0;
        wrapped_r[ch_idx] <= 1'b1;
      end else begin
        head_r[ch_idx] <= cur_head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_INIT;
      max_r <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        min_r <= MIN_INIT;
        max_r <= '0;
      end else begin
        min_r <= mn_new;
        max_r <= mx_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (accept) begin
      f1_valid_r <= 1'b1;
    end else if (q_push) begin
      f1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_val_r   <= val;
      f1_oldok_r <= wrapped_r[ch_idx];
      f1_range_r <= range_new;
      f1_chan_r  <= in_tuser;
      f1_last_r  <= in_tlast;
    end
  end

  // unwritten ring slots read as zero
  assign old_val = f1_oldok_r ? lag_rd_r : '0;
  assign delta   = f1_val_r - old_val + HALF;

  assign q_push = f1_valid_r && q_ready;
  assign q_data = {f1_last_r, f1_chan_r, f1_range_r, delta};

endmodule

[sv/ldm_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldm_fifo: short queue between front and back
// Register-based first-in first-out buffer; lets either side stall alone.
// ----------------------------------------------------------------------------
module ldm_fifo #(
  parameter int W = ldm_pkg::DEF_QE_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_en,
  output logic [W-1:0] rd_data
);
  import ldm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [W-1:0]     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign wr_ready = (count_r != CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[sv/ldm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldm_back: histogram update and batch report
// Read-modify-write of the delta histogram with one-deep forwarding, running
// peak, batch verdict and the result register. Batches are separated by an
// epoch tag on each histogram word; a tag wrap runs a clearing pass.
// ----------------------------------------------------------------------------
module ldm_back #(
  parameter int SAMPLE_BITS = ldm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  logic [2*SAMPLE_BITS+1:0]          q_data,
  input  logic [ldm_pkg::RANGE_W-1:0]       min_range,
  input  logic [ldm_pkg::COUNT_W-1:0]       count_limit,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ldm_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [15:0] peak_count,
                                                        // [27:16] sample_range,
                                                        // [28] data_ok
  output logic                              out_tuser,  // [0] batch_channel
  output logic                              hist_clearing
);
  import ldm_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int HIST_N = 1 << SB;
  localparam int WORD_W = EPOCH_W + COUNT_W;
  localparam int CMP_W  = (SB > RANGE_W) ? SB : RANGE_W;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } bk_state_t;

  bk_state_t state_r, state_nxt;

  logic [WORD_W-1:0]  hist_mem [HIST_N];
  logic [WORD_W-1:0]  rd_word_r;

  logic [SB-1:0]      clr_addr_r, clr_addr_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;

  logic               s1_valid_r;
  logic [SB-1:0]      s1_delta_r;
  logic [SB-1:0]      s1_range_r;
  logic               s1_chan_r;
  logic               s1_last_r;

  logic               fwd_valid_r;
  logic [SB-1:0]      fwd_addr_r;
  logic [COUNT_W-1:0] fwd_cnt_r;

  logic [COUNT_W-1:0] peak_r;

  logic               out_valid_r;
  logic [COUNT_W-1:0] out_peak_r;
  logic [RANGE_W-1:0] out_range_r;
  logic               out_ok_r;
  logic               out_chan_r;

  logic [SB-1:0]      q_delta;
  logic [SB-1:0]      q_range;
  logic               q_chan;
  logic               q_last;

  logic               s1_done;
  logic               s1_fire;
  logic               wrap_hold;
  logic [COUNT_W-1:0] mem_cnt;
  logic [COUNT_W-1:0] old_cnt;
  logic [COUNT_W-1:0] new_cnt;
  logic [COUNT_W-1:0] peak_new;
  logic               batch_ok;
  logic               wr_en;
  logic [SB-1:0]      wr_addr;
  logic [WORD_W-1:0]  wr_word;

  assign {q_last, q_chan, q_range, q_delta} = q_data;

  assign s1_done   = !s1_last_r || !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_done;
  // hold the queue while a batch closes on the last epoch
  assign wrap_hold = s1_valid_r && s1_last_r && (epoch_r == EPOCH_MAX);
  assign q_pop     = (state_r == ST_RUN) && q_valid && (!s1_valid_r || s1_done) &&
                     !wrap_hold;

  // stale epoch reads as an empty bin; forward the write that raced our read
  assign mem_cnt  = (rd_word_r[WORD_W-1:COUNT_W] == epoch_r) ? rd_word_r[COUNT_W-1:0] : '0;
  assign old_cnt  = (fwd_valid_r && fwd_addr_r == s1_delta_r) ? fwd_cnt_r : mem_cnt;
  assign new_cnt  = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
  assign peak_new = (new_cnt > peak_r) ? new_cnt : peak_r;
  assign batch_ok = (CMP_W'(s1_range_r) >= CMP_W'(min_range)) && (peak_new <= count_limit);

  assign wr_en   = s1_fire || (state_r == ST_CLEAR);
  assign wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : s1_delta_r;
  assign wr_word = (state_r == ST_CLEAR) ? '0 : {epoch_r, new_cnt};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_word_r <= hist_mem[q_delta];
    end
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_word;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    epoch_nxt    = epoch_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = ST_RUN;
          epoch_nxt = '0;
        end
      end
      ST_RUN: begin
        if (s1_fire && s1_last_r) begin
          if (epoch_r == EPOCH_MAX) begin
            state_nxt    = ST_CLEAR;
            clr_addr_nxt = '0;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt    = ST_CLEAR;
        clr_addr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      epoch_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      epoch_r    <= epoch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        fwd_valid_r <= !s1_last_r;
        peak_r      <= s1_last_r ? '0 : peak_new;
      end
      if (s1_fire && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_delta_r <= q_delta;
      s1_range_r <= q_range;
      s1_chan_r  <= q_chan;
      s1_last_r  <= q_last;
    end
    if (s1_fire) begin
      fwd_addr_r <= s1_delta_r;
      fwd_cnt_r  <= new_cnt;
    end
    if (s1_fire && s1_last_r) begin
      out_peak_r  <= peak_new;
      out_range_r <= RANGE_W'(s1_range_r);
      out_ok_r    <= batch_ok;
      out_chan_r  <= s1_chan_r;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {{OUT_PAD_W{1'b0}}, out_ok_r, out_range_r, out_peak_r};
  assign out_tuser     = out_chan_r;
  assign hist_clearing = (state_r == ST_CLEAR);

  // no sample may sit in the update stage while bins are being wiped
  a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !s1_valid_r)
    else $error("histogram update stage busy during clearing pass");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_last_r))
    else $error("result raised without a closing sample");

  a_peak_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (peak_r == '0))
    else $error("running peak not cleared at end of batch");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_last_r) |=> (fwd_valid_r && fwd_addr_r == $past(s1_delta_r)))
    else $error("forwarding register missed a histogram write");

endmodule

[sv/lagged_delta_min_entropy_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_delta_min_entropy_monitor: batch health test for converter samples
//
// Input stream: in_tdata[15:0] carries the raw converter word (low SAMPLE_BITS
// bits used), in_tuser the channel, in_tlast closes a batch. Each sample is
// differenced against the same channel's sample LAG_DISTANCE earlier and the
// centered delta is counted in a 2^SAMPLE_BITS-bin histogram.
// Output stream: one transaction per batch, with peak bin count, max-min range,
// pass flag in out_tdata and the closing sample's channel in out_tuser.
// Configuration: cfg_we writes min_range (index 0) or count_limit (index 1);
// write them only while the block is idle.
// Throughput: one sample per cycle unless stalled or clearing, set by the
// two-port histogram read-modify-write with forwarding. Latency: the closing
// sample runs through front register, queue and update stage to out_tvalid.
// Reset: a clearing pass over all 2^SAMPLE_BITS bins (4096 by default)
// wipes the histogram while in_tready stays low; the same pass repeats after
// every 256 batches when the 8-bit batch tag wraps.
// Stall: the result register holds while out_tready is low; samples keep
// flowing until a second batch result would need the register, then a 4-deep
// queue fills and in_tready drops.
// ----------------------------------------------------------------------------
module lagged_delta_min_entropy_monitor #(
  parameter int LAG_DISTANCE = ldm_pkg::DEF_LAG_DISTANCE,
  parameter int SAMPLE_BITS  = ldm_pkg::DEF_SAMPLE_BITS,
  parameter int CHANNELS     = ldm_pkg::DEF_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ldm_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] sample
  input  logic                              in_tuser,   // [0] channel
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ldm_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [15:0] peak_count,
                                                        // [27:16] sample_range,
                                                        // [28] data_ok
  output logic                              out_tuser,  // [0] batch_channel
  input  logic                              cfg_we,
  input  logic [ldm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ldm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ldm_pkg::*;

  localparam int QE_W = 2 * SAMPLE_BITS + 2;

  logic [RANGE_W-1:0] min_range_r;
  logic [COUNT_W-1:0] count_limit_r;

  logic            q_push;
  logic            q_ready;
  logic [QE_W-1:0] q_wdata;
  logic            q_valid;
  logic            q_pop;
  logic [QE_W-1:0] q_rdata;
  logic            hist_clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r   <= MIN_RANGE_RST;
      count_limit_r <= COUNT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_RANGE:   min_range_r   <= cfg_wdata[RANGE_W-1:0];
        REG_COUNT_LIMIT: count_limit_r <= cfg_wdata[COUNT_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  ldm_front #(
    .LAG_DISTANCE (LAG_DISTANCE),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CHANNELS     (CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .hist_clearing (hist_clearing),
    .q_push        (q_push),
    .q_ready       (q_ready),
    .q_data        (q_wdata)
  );

  ldm_fifo #(
    .W (QE_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_ready (q_ready),
    .wr_data  (q_wdata),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_rdata)
  );

  ldm_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_data        (q_rdata),
    .min_range     (min_range_r),
    .count_limit   (count_limit_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .hist_clearing (hist_clearing)
  );

endmodule
